[rtl/core/wl2tk_pkg.sv]
// shared types and constants of the weighted l2 top-k search core
// no dependencies; every other file in rtl/core refers to it by scoped names
package wl2tk_pkg;

  localparam int ELEM_W   = 16;
  localparam int WEIGHT_W = 15;
  localparam int SQ_W     = 32;
  localparam int TERM_W   = 47;
  localparam int DIST_W   = 63;
  localparam int LABEL_W  = 17;
  localparam int DIM_W    = 6;
  localparam int MODE_W   = 2;

  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int DIMS_W     = 7;
  localparam int NEIGH_W    = 5;

  localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DB     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOURS = 1'd1;

  localparam logic [DIMS_W-1:0]   DIMS_RESET  = 7'd64;
  localparam logic [NEIGH_W-1:0]  NEIGH_RESET = 5'd16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 15'd256;
  localparam logic [DIST_W-1:0]   DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [LABEL_W-1:0]  LABEL_NONE  = {LABEL_W{1'b1}};

  // one slot of the sorted list
  typedef struct packed {
    logic               valid;
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] label;
  } entry_t;

  // broadcast to every cell of the list
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic               clear;
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] label;
  } cell_cmd_t;

  // finished vector leaving the distance pipeline
  typedef struct packed {
    logic               insert;
    logic               report;
    logic [DIST_W-1:0]  distance;
    logic [LABEL_W-1:0] label;
  } ins_t;

endpackage

[rtl/core/wl2tk_if.sv]
// item and result channel interfaces of the weighted l2 top-k search core
// depends on wl2tk_pkg for field widths
interface wl2tk_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [wl2tk_pkg::MODE_W-1:0]           mode;
  logic [wl2tk_pkg::DIM_W-1:0]            dim_index;
  logic signed [wl2tk_pkg::ELEM_W-1:0]    element_value;
  logic                                   last_of_vector;
  logic                                   last_of_database;

  modport source (
    output valid, mode, dim_index, element_value, last_of_vector, last_of_database,
    input  ready
  );
  modport sink (
    input  valid, mode, dim_index, element_value, last_of_vector, last_of_database,
    output ready
  );
endinterface

interface wl2tk_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [wl2tk_pkg::DIST_W-1:0]           distance;
  logic signed [wl2tk_pkg::LABEL_W-1:0]   label;
  logic                                   last_in_run;

  modport source (
    output valid, distance, label, last_in_run,
    input  ready
  );
  modport sink (
    input  valid, distance, label, last_in_run,
    output ready
  );
endinterface

[rtl/core/wl2tk_cell.sv]
// one compare-and-shift cell of the sorted top-k list
// depends on wl2tk_pkg (entry_t, cell_cmd_t)
module wl2tk_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  wl2tk_pkg::cell_cmd_t cmd,
  input  wl2tk_pkg::entry_t    prev,
  input  logic                 prev_beat,
  input  wl2tk_pkg::entry_t    next,
  output wl2tk_pkg::entry_t    ent,
  output logic                 beat
);

  // strict compare: an equal distance already held stays ahead
  always_comb begin
    beat = !ent.valid || (cmd.distance < ent.distance);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (cmd.clear) begin
      ent.valid <= 1'b0;
    end else if (cmd.shift) begin
      ent <= next;
    end else if (cmd.insert && beat) begin
      if (prev_beat) begin
        ent <= prev;
      end else begin
        ent.valid    <= 1'b1;
        ent.distance <= cmd.distance;
        ent.label    <= cmd.label;
      end
    end
  end

endmodule

[rtl/core/wl2tk_dist.sv]
// weight and query stores, weighted squared difference pipeline and
// saturating per-vector accumulator; depends on wl2tk_pkg
module wl2tk_dist #(
  parameter int DIM_MAX = 64,
  parameter int DB_MAX  = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [wl2tk_pkg::MODE_W-1:0]       mode,
  input  logic [wl2tk_pkg::DIM_W-1:0]        dim_index,
  input  logic signed [wl2tk_pkg::ELEM_W-1:0] element_value,
  input  logic                               last_of_vector,
  input  logic                               last_of_database,
  input  logic [wl2tk_pkg::DIMS_W-1:0]       dims_used,
  output wl2tk_pkg::ins_t                    ins
);

  localparam int AW    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int CNT_W = $clog2(DB_MAX + 1);

  logic [wl2tk_pkg::WEIGHT_W-1:0] wmem [DIM_MAX];
  logic [wl2tk_pkg::ELEM_W-1:0]   qmem [DIM_MAX];
  logic [DIM_MAX-1:0]             wvalid;
  logic [DIM_MAX-1:0]             qvalid;

  logic [AW-1:0] addr;
  logic          in_store;
  logic          is_db;

  // stage 1: store read data
  logic                             p1_valid, p1_inrange, p1_endv, p1_endd;
  logic [wl2tk_pkg::WEIGHT_W-1:0]   p1_w;
  logic [wl2tk_pkg::ELEM_W-1:0]     p1_q;
  logic                             p1_wv, p1_qv;
  logic signed [wl2tk_pkg::ELEM_W-1:0] p1_e;
  // stage 2: squared difference
  logic                             p2_valid, p2_endv, p2_endd;
  logic [wl2tk_pkg::SQ_W-1:0]       p2_sq;
  logic [wl2tk_pkg::WEIGHT_W-1:0]   p2_w;
  // stage 3: weighted term
  logic                             p3_valid, p3_endv, p3_endd;
  logic [wl2tk_pkg::TERM_W-1:0]     p3_term;

  logic [wl2tk_pkg::DIST_W-1:0]     running_sum;
  logic [CNT_W-1:0]                 vector_counter;

  logic [wl2tk_pkg::WEIGHT_W-1:0]   w_eff;
  logic signed [wl2tk_pkg::ELEM_W:0] diff;
  logic [wl2tk_pkg::ELEM_W:0]       mag17;
  logic [wl2tk_pkg::ELEM_W-1:0]     mag;
  logic [wl2tk_pkg::TERM_W-1:0]     term_next;
  logic [wl2tk_pkg::DIST_W:0]       sum_wide;
  logic [wl2tk_pkg::DIST_W-1:0]     sum_next;
  logic                             room;

  assign addr     = AW'(dim_index);
  assign in_store = 32'(dim_index) < DIM_MAX;
  assign is_db    = accept && (mode == wl2tk_pkg::MODE_DB);

  // stores: written and read at the accept edge
  always_ff @(posedge clk) begin
    if (accept && in_store && (mode == wl2tk_pkg::MODE_WEIGHT)) begin
      wmem[addr] <= element_value[wl2tk_pkg::ELEM_W-1] ? '0
                  : element_value[wl2tk_pkg::WEIGHT_W-1:0];
    end
    if (accept && in_store && (mode == wl2tk_pkg::MODE_QUERY)) begin
      qmem[addr] <= element_value;
    end
    p1_w <= wmem[addr];
    p1_q <= qmem[addr];
    p1_e <= element_value;
  end

  // unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      qvalid <= '0;
    end else begin
      if (accept && in_store && (mode == wl2tk_pkg::MODE_WEIGHT)) wvalid[addr] <= 1'b1;
      if (accept && in_store && (mode == wl2tk_pkg::MODE_QUERY))  qvalid[addr] <= 1'b1;
    end
    p1_wv <= wvalid[addr];
    p1_qv <= qvalid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= is_db;
    end
    p1_inrange <= in_store && ({1'b0, dim_index} < dims_used);
    p1_endv    <= last_of_vector || last_of_database;
    p1_endd    <= last_of_database;
  end

  // stage 1 -> 2: difference and square
  always_comb begin
    w_eff = p1_wv ? p1_w : wl2tk_pkg::WEIGHT_ONE;
    diff  = $signed({p1_qv ? p1_q[wl2tk_pkg::ELEM_W-1] : 1'b0,
                     p1_qv ? p1_q : {wl2tk_pkg::ELEM_W{1'b0}}})
          - $signed({p1_e[wl2tk_pkg::ELEM_W-1], p1_e});
    mag17 = diff[wl2tk_pkg::ELEM_W] ? 17'(-diff) : 17'(diff);
    mag   = mag17[wl2tk_pkg::ELEM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_sq   <= p1_inrange ? {16'b0, mag} * {16'b0, mag} : '0;
    p2_w    <= w_eff;
    p2_endv <= p1_endv;
    p2_endd <= p1_endd;
  end

  // stage 2 -> 3: weight multiply
  assign term_next = {15'b0, p2_sq} * {32'b0, p2_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_term <= term_next;
    p3_endv <= p2_endv;
    p3_endd <= p2_endd;
  end

  // stage 3: saturating accumulate, hand finished vector to the list
  always_comb begin
    sum_wide = {1'b0, running_sum} + {17'b0, p3_term};
    sum_next = sum_wide[wl2tk_pkg::DIST_W] ? wl2tk_pkg::DIST_MAX
             : sum_wide[wl2tk_pkg::DIST_W-1:0];
    room     = 32'(vector_counter) < DB_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      vector_counter <= '0;
      ins.insert     <= 1'b0;
      ins.report     <= 1'b0;
    end else begin
      ins.insert <= p3_valid && p3_endv && room;
      ins.report <= p3_valid && p3_endd;
      if (p3_valid) begin
        if (p3_endv) begin
          running_sum <= '0;
          if (p3_endd) begin
            vector_counter <= '0;
          end else if (room) begin
            vector_counter <= vector_counter + CNT_W'(1);
          end
        end else begin
          running_sum <= sum_next;
        end
      end
    end
    ins.distance <= sum_next;
    ins.label    <= wl2tk_pkg::LABEL_W'(vector_counter);
  end

endmodule

[rtl/core/weighted_l2_topk_search_core.sv]
// top level of the weighted l2 top-k search core: config registers,
// list of compare-shift cells, report sequencer and result register
// depends on wl2tk_pkg, wl2tk_if, wl2tk_dist, wl2tk_cell
//
// usage:
//   item_ch carries weight writes, query writes and database elements;
//   result_ch returns the (distance, label) report, last_in_run on its final item.
//   config registers dims_used (index 0) and neighbours_wanted (index 1) are
//   written through cfg_we / cfg_index / cfg_data while the core is idle.
// input and report flow:
//   weight, query and database items are taken one per cycle while the
//   input is open; a vector's sum reaches the list through the store
//   read, square, weight multiply and accumulate stages.
//   the item carrying last_of_database closes the input until the last
//   result is loaded: the pipeline drains, then the result register
//   paces the report, and a stall on result_ch keeps it closed longer.
// reset:
//   synchronous, active high; weights read as 1.0 and query as zero until
//   written, the list is empty, dims_used 64, neighbours_wanted 16.
// stall:
//   a held result register stops the list from shifting; nothing is lost.
module weighted_l2_topk_search_core #(
  parameter int DIM_MAX = 64,
  parameter int K_MAX   = 16,
  parameter int DB_MAX  = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [wl2tk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wl2tk_pkg::CFG_DATA_W-1:0]      cfg_data,
  wl2tk_in_if.sink                              item_ch,
  wl2tk_out_if.source                           result_ch
);

  localparam int KW = $clog2(K_MAX + 1);

  logic [wl2tk_pkg::DIMS_W-1:0]  dims_used;
  logic [wl2tk_pkg::NEIGH_W-1:0] neighbours_wanted;

  logic                          busy;
  logic                          accept;
  wl2tk_pkg::ins_t               ins;

  wl2tk_pkg::cell_cmd_t          cmd;
  wl2tk_pkg::entry_t             ents  [K_MAX];
  logic [K_MAX-1:0]              beats;
  logic [K_MAX-1:0]              cell_valid;

  logic                          rep_active;
  logic [KW-1:0]                 rep_count;
  logic [KW-1:0]                 want;
  logic                          load;
  logic                          load_last;

  logic                          out_valid;
  logic [wl2tk_pkg::DIST_W-1:0]  out_dist;
  logic [wl2tk_pkg::LABEL_W-1:0] out_label;
  logic                          out_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used         <= wl2tk_pkg::DIMS_RESET;
      neighbours_wanted <= wl2tk_pkg::NEIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wl2tk_pkg::REG_DIMS_USED:  dims_used <= cfg_data;
        wl2tk_pkg::REG_NEIGHBOURS: neighbours_wanted <= cfg_data[wl2tk_pkg::NEIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: closed from the database end until the report is loaded
  assign item_ch.ready = !busy;
  assign accept        = item_ch.valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (item_ch.mode == wl2tk_pkg::MODE_DB) && item_ch.last_of_database) begin
      busy <= 1'b1;
    end else if (load_last) begin
      busy <= 1'b0;
    end
  end

  wl2tk_dist #(
    .DIM_MAX (DIM_MAX),
    .DB_MAX  (DB_MAX)
  ) u_dist (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .mode             (item_ch.mode),
    .dim_index        (item_ch.dim_index),
    .element_value    (item_ch.element_value),
    .last_of_vector   (item_ch.last_of_vector),
    .last_of_database (item_ch.last_of_database),
    .dims_used        (dims_used),
    .ins              (ins)
  );

  // report length: zero asks for one, capped at the list depth
  always_comb begin
    if (neighbours_wanted == '0) begin
      want = KW'(1);
    end else if (32'(neighbours_wanted) > K_MAX) begin
      want = KW'(K_MAX);
    end else begin
      want = KW'(neighbours_wanted);
    end
  end

  assign load      = rep_active && (!out_valid || result_ch.ready);
  assign load_last = load && ((rep_count + KW'(1)) == want);

  // one command drives the whole row; the head cell feeds the result register
  always_comb begin
    cmd.insert   = ins.insert;
    cmd.shift    = load;
    cmd.clear    = load_last;
    cmd.distance = ins.distance;
    cmd.label    = ins.label;
  end

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    wl2tk_pkg::entry_t prev_ent;
    wl2tk_pkg::entry_t next_ent;
    logic              prev_beat;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_beat = 1'b0;
    end else begin : g_body
      assign prev_ent  = ents[i-1];
      assign prev_beat = beats[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    wl2tk_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev      (prev_ent),
      .prev_beat (prev_beat),
      .next      (next_ent),
      .ent       (ents[i]),
      .beat      (beats[i])
    );

    assign cell_valid[i] = ents[i].valid;
  end

  // report sequencer: starts once the final vector has been entered
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_active <= 1'b0;
      rep_count  <= '0;
    end else if (ins.report) begin
      rep_active <= 1'b1;
      rep_count  <= '0;
    end else if (load_last) begin
      rep_active <= 1'b0;
      rep_count  <= '0;
    end else if (load) begin
      rep_count <= rep_count + KW'(1);
    end
  end

  // result register; empty slots go out as padding
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_dist  <= ents[0].valid ? ents[0].distance : wl2tk_pkg::DIST_MAX;
      out_label <= ents[0].valid ? ents[0].label    : wl2tk_pkg::LABEL_NONE;
      out_last  <= load_last;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.distance    = out_dist;
  assign result_ch.label       = out_label;
  assign result_ch.last_in_run = out_last;

  // held entries always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("list entries not contiguous");

  // a report only runs with the input closed
  a_closed: assert property (@(posedge clk) disable iff (rst)
    rep_active |-> busy)
    else $error("report running with input open");

  // the list is empty after the final result is loaded
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (cell_valid == '0))
    else $error("list not cleared after report");

  // the report never runs past its length
  a_count: assert property (@(posedge clk) disable iff (rst)
    rep_active |-> (rep_count < want))
    else $error("report count past length");

  // no new vector enters the list during a report
  a_no_insert: assert property (@(posedge clk) disable iff (rst)
    rep_active |-> !ins.insert)
    else $error("insert during report");

endmodule
